### design/frame_slot_mailbox_core_defines.svh
// Assertion macros used by the mailbox controller.
`ifndef FRAME_SLOT_MAILBOX_CORE_DEFINES_SVH
`define FRAME_SLOT_MAILBOX_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSMB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fsmb_pkg.sv
package fsmb_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SER_W      = 64;

    typedef enum logic [2:0] {
        OP_CLAIM    = 3'd0,
        OP_FENCE_OK = 3'd1,
        OP_FENCE_NG = 3'd2,
        OP_ACQUIRE  = 3'd3,
        OP_RELEASE  = 3'd4,
        OP_REJECT   = 3'd5,
        OP_ENABLE   = 3'd6,
        OP_SHUTDOWN = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        PH_FREE      = 2'd0,
        PH_PRODUCING = 2'd1,
        PH_READY     = 2'd2,
        PH_ACQUIRED  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_BUSY    = 2'd1,
        STS_UNAVAIL = 2'd2,
        STS_IGNORED = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

### design/fsmb_ctrl.sv
module fsmb_ctrl
    import fsmb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

`include "frame_slot_mailbox_core_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_OUT    = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (i_sts.scan_last) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_OUT;
            ST_OUT:    if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_OUT);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.commit = (r_state == ST_COMMIT);

    `FSMB_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == ST_SCAN, "accepted beat did not start a scan")
    `FSMB_ASSERT_NEXT(a_commit_then_out, i_clk, i_rst_n, r_state == ST_COMMIT,
        o_out_valid && !o_in_ready, "commit not followed by result beat")
    `FSMB_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result beat dropped while stalled")

endmodule

### design/fsmb_dp.sv
module fsmb_dp
    import fsmb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic [2:0]       i_cmd,
    input  logic [3:0]       i_slot_index,
    input  logic [SER_W-1:0] i_serial,
    input  t_dp_cmd          i_ctl,
    output t_dp_sts          o_sts,
    output logic [1:0]       o_status,
    output logic [3:0]       o_granted_slot,
    output logic [SER_W-1:0] o_granted_serial,
    output logic             o_dropped_frame
);

    // persistent state
    logic               r_cfg;
    logic               r_active, n_active;
    logic               r_unavail, n_unavail;
    logic [SER_W-1:0]   r_counter, n_counter;
    t_phase             r_phase  [SLOT_COUNT];
    t_phase             n_phase  [SLOT_COUNT];
    logic [SER_W-1:0]   r_serial [SLOT_COUNT];
    logic [SER_W-1:0]   n_serial [SLOT_COUNT];

    // captured beat
    t_op                r_op;
    logic [3:0]         r_sidx;
    logic               r_in_range;
    logic [SER_W-1:0]   r_ser;

    // scan accumulators
    logic [SLOT_W-1:0]  r_scan;
    logic               r_free_found;
    logic [SLOT_W-1:0]  r_free_idx;
    logic               r_rdy_found;
    logic [SLOT_W-1:0]  r_rdy_idx;
    logic [SER_W-1:0]   r_rdy_ser;
    logic               r_acq_found;
    logic [SLOT_W-1:0]  r_acq_idx;
    logic [SER_W-1:0]   r_acq_ser;
    t_phase             r_tgt_phase;
    logic               r_tgt_match;

    // result
    t_status            r_status, n_status;
    logic [3:0]         r_gslot, n_gslot;
    logic [SER_W-1:0]   r_gser, n_gser;
    logic               r_drop, n_drop;

    t_phase             w_ph;
    logic [SER_W-1:0]   w_sr;
    logic               w_last;
    logic               w_tgt;
    logic [SER_W-1:0]   w_cnt_inc;
    logic [SLOT_W-1:0]  w_pick;

    assign w_ph      = r_phase[r_scan];
    assign w_sr      = r_serial[r_scan];
    assign w_last    = (r_scan == SLOT_W'(SLOT_COUNT - 1));
    assign w_tgt     = r_in_range && (r_scan == r_sidx[SLOT_W-1:0]);
    assign w_cnt_inc = r_counter + SER_W'(1);
    assign w_pick    = r_free_found ? r_free_idx : r_rdy_idx;

    assign o_sts.scan_last = w_last;

    // commit: one update per beat from the scan summary
    always_comb begin
        n_phase   = r_phase;
        n_serial  = r_serial;
        n_counter = r_counter;
        n_active  = r_active;
        n_unavail = r_unavail;
        n_status  = STS_DONE;
        n_gslot   = '0;
        n_gser    = '0;
        n_drop    = 1'b0;
        unique case (r_op)
            OP_CLAIM: begin
                if (!r_cfg || r_unavail) begin
                    n_status = STS_UNAVAIL;
                end else if (!r_free_found && !r_rdy_found) begin
                    n_status = STS_BUSY;
                end else begin
                    n_counter        = w_cnt_inc;
                    n_serial[w_pick] = w_cnt_inc;
                    n_phase[w_pick]  = PH_PRODUCING;
                    n_active         = 1'b1;
                    n_gslot          = 4'(w_pick);
                    n_gser           = w_cnt_inc;
                    n_drop           = !r_free_found;
                end
            end
            OP_FENCE_OK, OP_FENCE_NG: begin
                if (r_in_range && r_tgt_phase == PH_PRODUCING) begin
                    if (r_op == OP_FENCE_OK) begin
                        n_phase[r_sidx[SLOT_W-1:0]] = PH_READY;
                    end else begin
                        n_phase[r_sidx[SLOT_W-1:0]]  = PH_FREE;
                        n_serial[r_sidx[SLOT_W-1:0]] = '0;
                    end
                end else begin
                    n_status = STS_IGNORED;
                end
            end
            OP_ACQUIRE: begin
                if (!r_active) begin
                    n_status = STS_UNAVAIL;
                end else begin
                    // every ready slot but the winner goes back to free
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (r_phase[i] == PH_READY &&
                            !(r_acq_found && r_acq_idx == SLOT_W'(i))) begin
                            n_phase[i] = PH_FREE;
                        end
                    end
                    if (r_acq_found) begin
                        n_phase[r_acq_idx] = PH_ACQUIRED;
                        n_gslot            = 4'(r_acq_idx);
                        n_gser             = r_acq_ser;
                    end else begin
                        n_status = STS_BUSY;
                    end
                end
            end
            OP_RELEASE: begin
                if (r_in_range && r_tgt_phase == PH_ACQUIRED && r_tgt_match) begin
                    n_phase[r_sidx[SLOT_W-1:0]] = PH_FREE;
                end else begin
                    n_status = STS_IGNORED;
                end
            end
            OP_REJECT: begin
                n_unavail = 1'b1;
                n_active  = 1'b0;
            end
            OP_ENABLE: begin
                n_unavail = 1'b0;
                n_active  = 1'b0;
            end
            OP_SHUTDOWN: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    n_phase[i]  = PH_FREE;
                    n_serial[i] = '0;
                end
                n_counter = '0;
                n_active  = 1'b0;
                n_unavail = 1'b0;
            end
            default: n_status = STS_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= 1'b0;
            r_active  <= 1'b0;
            r_unavail <= 1'b0;
            r_counter <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_phase[i]  <= PH_FREE;
                r_serial[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (i_ctl.commit) begin
                r_active  <= n_active;
                r_unavail <= n_unavail;
                r_counter <= n_counter;
                r_phase   <= n_phase;
                r_serial  <= n_serial;
            end
        end
    end

    // payload, scan and result registers; load seeds payload and scan before use
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op         <= t_op'(i_cmd);
            r_sidx       <= i_slot_index;
            r_in_range   <= ({1'b0, i_slot_index} < 5'(SLOT_COUNT));
            r_ser        <= i_serial;
            r_scan       <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_rdy_found  <= 1'b0;
            r_rdy_idx    <= '0;
            r_rdy_ser    <= '0;
            r_acq_found  <= 1'b0;
            r_acq_idx    <= '0;
            r_acq_ser    <= i_serial;
            r_tgt_phase  <= PH_FREE;
            r_tgt_match  <= 1'b0;
        end else if (i_ctl.scan) begin
            if (!w_last) begin
                r_scan <= r_scan + SLOT_W'(1);
            end
            if (w_ph == PH_FREE && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_scan;
            end
            // oldest ready frame, lower index on a tie
            if (w_ph == PH_READY && (!r_rdy_found || w_sr < r_rdy_ser)) begin
                r_rdy_found <= 1'b1;
                r_rdy_idx   <= r_scan;
                r_rdy_ser   <= w_sr;
            end
            // newest ready frame above the caller's serial
            if (w_ph == PH_READY && w_sr > r_acq_ser) begin
                r_acq_found <= 1'b1;
                r_acq_idx   <= r_scan;
                r_acq_ser   <= w_sr;
            end
            if (w_tgt) begin
                r_tgt_phase <= w_ph;
                r_tgt_match <= (w_sr == r_ser);
            end
        end
        if (i_ctl.commit) begin
            r_status <= n_status;
            r_gslot  <= n_gslot;
            r_gser   <= n_gser;
            r_drop   <= n_drop;
        end
    end

    assign o_status         = r_status;
    assign o_granted_slot   = r_gslot;
    assign o_granted_serial = r_gser;
    assign o_dropped_frame  = r_drop;

endmodule

### design/frame_slot_mailbox_core.sv
// Channel   Handshake                      Payload
// -------   ----------------------------   ------------------------------------------
// in        i_in_valid / o_in_ready        i_cmd, i_slot_index, i_serial
// out       o_out_valid / i_out_ready      o_status, o_granted_slot, o_granted_serial,
//                                          o_dropped_frame
// cfg       i_cfg_wr_en (no wait)          i_cfg_wr_data (shared path requested)
//
// One command beat in, one result beat out. A beat walks the slot table one
// entry per cycle (one wide compare unit set), then a commit step, then the
// result is presented.
// One beat at a time: o_in_ready is high only with no beat in flight.
// Reset (i_rst_n low, synchronous) frees all slots, zeroes serials and the
// serial counter, clears the path flags and the config bit.
// A stalled output holds its result; no new beat is taken until it drains.
module frame_slot_mailbox_core
    import fsmb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    // command beat
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_cmd,
    input  logic [3:0]       i_slot_index,
    input  logic [SER_W-1:0] i_serial,
    // result beat
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [3:0]       o_granted_slot,
    output logic [SER_W-1:0] o_granted_serial,
    output logic             o_dropped_frame
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: accept, scan, commit, present
    fsmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // slot table, serial counter, path flags and result registers
    fsmb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (i_cmd),
        .i_slot_index     (i_slot_index),
        .i_serial         (i_serial),
        .i_ctl            (w_cmd),
        .o_sts            (w_sts),
        .o_status         (o_status),
        .o_granted_slot   (o_granted_slot),
        .o_granted_serial (o_granted_serial),
        .o_dropped_frame  (o_dropped_frame)
    );

endmodule
